// File: sv/crc8pfr_pkg.sv
// Shared constants, codes and controller/datapath interface types for the
// CRC-8 frame receiver. No dependencies.
`timescale 1ns / 1ps

package crc8pfr_pkg;

    localparam int PAYLOAD_DEPTH = 16;
    localparam int RESULT_LIMIT  = 16;
    localparam int ACCEPT_CAP    = (PAYLOAD_DEPTH < RESULT_LIMIT) ? PAYLOAD_DEPTH
                                                                  : RESULT_LIMIT;
    localparam int RAM_AW        = (ACCEPT_CAP > 1) ? $clog2(ACCEPT_CAP) : 1;

    localparam int BYTE_W    = 8;
    localparam int LEN_W     = 5;
    localparam int IDX_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_BYTE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN   = 2'd1;

    localparam logic [BYTE_W-1:0] SYNC_RESET    = 8'hAA;
    localparam logic [LEN_W-1:0]  MAX_LEN_RESET = 5'd16;
    localparam logic [BYTE_W-1:0] CRC_POLY      = 8'h07;

    // controller -> datapath
    typedef struct packed {
        logic clr_crc;     // sync seen, restart CRC
        logic ld_addr;
        logic ld_type;
        logic ld_len;      // also clears byte count
        logic st_data;     // write payload byte, bump count
        logic drain_start; // clear drain counter
        logic rd_issue;    // read payload RAM at drain counter
        logic out_load;    // load result register, bump drain counter
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic sync_hit;
        logic len_ok;
        logic len_zero;
        logic data_done;
        logic crc_match;
        logic drain_last;
        logic out_free;
    } dp_sts_t;

endpackage

// File: sv/crc8_packet_frame_receiver.sv
// Top level of the CRC-8 sync/length framed packet receiver.
// Depends on crc8pfr_pkg, crc8pfr_ctrl, crc8pfr_dp (and crc8pfr_ram below it).
`timescale 1ns / 1ps
//
//  channel   | ports                                   | role
//  ----------+-----------------------------------------+-----------------------------
//  input     | s_valid, s_ready, s_rx_byte             | one link byte per transfer
//  result    | m_valid, m_ready, m_frame_addr ... m_last| one payload byte per transfer
//  config    | cfg_we, cfg_idx, cfg_wdata              | 0: sync byte, 1: max length
//
// A CRC byte that matches stops input and drains the frame: for each result,
// a payload RAM read, then a load of the result register, which waits while
// the result register is still full and m_ready is low; input reopens as soon
// as the last result is loaded, while it still waits to be taken.
// Reset (aresetn, synchronous, active low) returns to hunting, restores the
// config defaults and empties the result register; s_ready is registered and
// rises in the cycle after reset is released. Payload RAM is not cleared.
//
// Frame: SYNC ADDR TYPE LEN PAYLOAD[LEN] CRC. CRC-8 poly 0x07, init 0,
// MSB first, over ADDR..PAYLOAD. Bad CRC or oversize LEN drops back to hunt.

module crc8_packet_frame_receiver (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_we,
    input  logic [crc8pfr_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]      cfg_wdata,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]      s_rx_byte,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [crc8pfr_pkg::BYTE_W-1:0]      m_frame_addr,
    output logic [crc8pfr_pkg::BYTE_W-1:0]      m_frame_type,
    output logic [crc8pfr_pkg::LEN_W-1:0]       m_frame_len,
    output logic [crc8pfr_pkg::BYTE_W-1:0]      m_data_byte,
    output logic [crc8pfr_pkg::IDX_W-1:0]       m_data_index,
    output logic                                m_last
);

    crc8pfr_pkg::ctrl_cmd_t cmd;
    crc8pfr_pkg::dp_sts_t   sts;

    // phase sequencing and handshake control
    crc8pfr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    // header registers, running CRC, payload store, result register
    crc8pfr_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .rx_byte      (s_rx_byte),
        .cmd          (cmd),
        .sts          (sts),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_addr (m_frame_addr),
        .m_frame_type (m_frame_type),
        .m_frame_len  (m_frame_len),
        .m_data_byte  (m_data_byte),
        .m_data_index (m_data_index),
        .m_last       (m_last)
    );

endmodule

// File: sv/crc8pfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module crc8pfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: sv/crc8pfr_dp.sv
// Datapath: config registers, header holding registers, running CRC,
// payload RAM and result register. Depends on crc8pfr_pkg, crc8pfr_ram.
`timescale 1ns / 1ps

module crc8pfr_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [crc8pfr_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]      cfg_wdata,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]      rx_byte,
    input  crc8pfr_pkg::ctrl_cmd_t              cmd,
    output crc8pfr_pkg::dp_sts_t                sts,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [crc8pfr_pkg::BYTE_W-1:0]      m_frame_addr,
    output logic [crc8pfr_pkg::BYTE_W-1:0]      m_frame_type,
    output logic [crc8pfr_pkg::LEN_W-1:0]       m_frame_len,
    output logic [crc8pfr_pkg::BYTE_W-1:0]      m_data_byte,
    output logic [crc8pfr_pkg::IDX_W-1:0]       m_data_index,
    output logic                                m_last
);

    // CRC-8, poly 0x07, MSB first, one byte
    function automatic logic [crc8pfr_pkg::BYTE_W-1:0] crc8_feed(
        input logic [crc8pfr_pkg::BYTE_W-1:0] crc,
        input logic [crc8pfr_pkg::BYTE_W-1:0] b
    );
        logic [crc8pfr_pkg::BYTE_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < crc8pfr_pkg::BYTE_W; k++) begin
            if (c[crc8pfr_pkg::BYTE_W-1]) begin
                c = {c[crc8pfr_pkg::BYTE_W-2:0], 1'b0} ^ crc8pfr_pkg::CRC_POLY;
            end else begin
                c = {c[crc8pfr_pkg::BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    logic [crc8pfr_pkg::BYTE_W-1:0] sync_reg;
    logic [crc8pfr_pkg::LEN_W-1:0]  max_len_reg;
    logic [crc8pfr_pkg::BYTE_W-1:0] addr_reg;
    logic [crc8pfr_pkg::BYTE_W-1:0] type_reg;
    logic [crc8pfr_pkg::LEN_W-1:0]  len_reg;
    logic [crc8pfr_pkg::LEN_W-1:0]  count_reg;
    logic [crc8pfr_pkg::LEN_W-1:0]  drain_reg;
    logic [crc8pfr_pkg::BYTE_W-1:0] crc_reg;

    logic                           out_valid_reg;
    logic [crc8pfr_pkg::BYTE_W-1:0] out_addr_reg;
    logic [crc8pfr_pkg::BYTE_W-1:0] out_type_reg;
    logic [crc8pfr_pkg::LEN_W-1:0]  out_len_reg;
    logic [crc8pfr_pkg::BYTE_W-1:0] out_data_reg;
    logic [crc8pfr_pkg::IDX_W-1:0]  out_index_reg;
    logic                           out_last_reg;

    logic [crc8pfr_pkg::LEN_W-1:0]  limit;
    logic [crc8pfr_pkg::LEN_W-1:0]  count_inc;
    logic [crc8pfr_pkg::LEN_W-1:0]  drain_inc;
    logic [crc8pfr_pkg::LEN_W-1:0]  run_len;
    logic [crc8pfr_pkg::BYTE_W-1:0] crc_next;
    logic [crc8pfr_pkg::BYTE_W-1:0] ram_q;

    assign limit = (max_len_reg > crc8pfr_pkg::LEN_W'(crc8pfr_pkg::ACCEPT_CAP))
                 ? crc8pfr_pkg::LEN_W'(crc8pfr_pkg::ACCEPT_CAP) : max_len_reg;
    assign count_inc = count_reg + crc8pfr_pkg::LEN_W'(1);
    assign drain_inc = drain_reg + crc8pfr_pkg::LEN_W'(1);
    // empty payload still yields one result
    assign run_len   = (len_reg == '0) ? crc8pfr_pkg::LEN_W'(1) : len_reg;
    assign crc_next  = crc8_feed(crc_reg, rx_byte);

    always_comb begin
        sts.sync_hit   = (rx_byte == sync_reg);
        sts.len_ok     = (rx_byte <= {{(crc8pfr_pkg::BYTE_W - crc8pfr_pkg::LEN_W){1'b0}},
                                      limit});
        sts.len_zero   = (rx_byte == '0);
        sts.data_done  = (count_inc >= len_reg);
        sts.crc_match  = (crc_reg == rx_byte);
        sts.drain_last = (drain_inc >= run_len);
        sts.out_free   = !out_valid_reg || m_ready;
    end

    // config registers; out-of-range index is dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_reg    <= crc8pfr_pkg::SYNC_RESET;
            max_len_reg <= crc8pfr_pkg::MAX_LEN_RESET;
        end else if (cfg_we) begin
            case (cfg_idx)
                crc8pfr_pkg::CFG_SYNC_BYTE: sync_reg    <= cfg_wdata;
                crc8pfr_pkg::CFG_MAX_LEN:   max_len_reg <= cfg_wdata[crc8pfr_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_reg  <= '0;
            type_reg  <= '0;
            len_reg   <= '0;
            count_reg <= '0;
            drain_reg <= '0;
            crc_reg   <= '0;
        end else begin
            if (cmd.clr_crc) begin
                crc_reg <= '0;
            end else if (cmd.ld_addr || cmd.ld_type || cmd.ld_len || cmd.st_data) begin
                crc_reg <= crc_next;
            end
            if (cmd.ld_addr) begin
                addr_reg <= rx_byte;
            end
            if (cmd.ld_type) begin
                type_reg <= rx_byte;
            end
            if (cmd.ld_len) begin
                len_reg   <= rx_byte[crc8pfr_pkg::LEN_W-1:0];
                count_reg <= '0;
            end else if (cmd.st_data) begin
                count_reg <= count_inc;
            end
            if (cmd.drain_start) begin
                drain_reg <= '0;
            end else if (cmd.out_load) begin
                drain_reg <= drain_inc;
            end
        end
    end

    crc8pfr_ram #(
        .WIDTH (crc8pfr_pkg::BYTE_W),
        .DEPTH (crc8pfr_pkg::ACCEPT_CAP)
    ) u_payload_ram (
        .aclk  (aclk),
        .we    (cmd.st_data),
        .waddr (count_reg[crc8pfr_pkg::RAM_AW-1:0]),
        .wdata (rx_byte),
        .re    (cmd.rd_issue),
        .raddr (drain_reg[crc8pfr_pkg::RAM_AW-1:0]),
        .rdata (ram_q)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_addr_reg  <= addr_reg;
            out_type_reg  <= type_reg;
            out_len_reg   <= len_reg;
            out_data_reg  <= (len_reg == '0) ? '0 : ram_q;
            out_index_reg <= (len_reg == '0) ? '0 : drain_reg[crc8pfr_pkg::IDX_W-1:0];
            out_last_reg  <= sts.drain_last;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_addr = out_addr_reg;
    assign m_frame_type = out_type_reg;
    assign m_frame_len  = out_len_reg;
    assign m_data_byte  = out_data_reg;
    assign m_data_index = out_index_reg;
    assign m_last       = out_last_reg;

endmodule

// File: sv/crc8pfr_ctrl.sv
// Frame controller: phase state machine driving the datapath commands.
// Depends on crc8pfr_pkg.
`timescale 1ns / 1ps

module crc8pfr_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  crc8pfr_pkg::dp_sts_t     sts,
    output crc8pfr_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_ADDR,
        ST_TYPE,
        ST_LEN,
        ST_DATA,
        ST_CRC,
        ST_RD,
        ST_WR
    } state_t;

    state_t state_reg, state_next;
    logic   s_ready_reg, s_ready_next;
    logic   acc;

    assign acc     = s_valid && s_ready_reg;
    assign s_ready = s_ready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT: begin
                if (acc && sts.sync_hit) begin
                    cmd.clr_crc = 1'b1;
                    state_next  = ST_ADDR;
                end
            end
            ST_ADDR: begin
                if (acc) begin
                    cmd.ld_addr = 1'b1;
                    state_next  = ST_TYPE;
                end
            end
            ST_TYPE: begin
                if (acc) begin
                    cmd.ld_type = 1'b1;
                    state_next  = ST_LEN;
                end
            end
            ST_LEN: begin
                if (acc) begin
                    if (sts.len_ok) begin
                        cmd.ld_len = 1'b1;
                        state_next = sts.len_zero ? ST_CRC : ST_DATA;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA: begin
                if (acc) begin
                    cmd.st_data = 1'b1;
                    if (sts.data_done) begin
                        state_next = ST_CRC;
                    end
                end
            end
            ST_CRC: begin
                if (acc) begin
                    if (sts.crc_match) begin
                        cmd.drain_start = 1'b1;
                        state_next      = ST_RD;
                    end else begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_RD: begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_WR;
            end
            ST_WR: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = sts.drain_last ? ST_HUNT : ST_RD;
                end
            end
            default: state_next = ST_HUNT;
        endcase
    end

    assign s_ready_next = (state_next != ST_RD) && (state_next != ST_WR);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_HUNT;
            s_ready_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            s_ready_reg <= s_ready_next;
        end
    end

`ifndef SYNTHESIS
    a_rd_then_wr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_RD |=> state_reg == ST_WR)
        else $error("payload read not followed by result load");

    a_wr_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WR && !sts.out_free) |=> state_reg == ST_WR)
        else $error("drain left while result register busy");

    a_good_crc_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CRC && acc && sts.crc_match) |=> (state_reg == ST_RD && !s_ready))
        else $error("matching CRC did not start drain");

    a_no_input_in_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD || state_reg == ST_WR) |-> !s_ready_reg)
        else $error("input ready during drain");
`endif

endmodule

// File: tb/sv/crc8pfr_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the CRC-8 frame receiver: tracks config writes and link byte
// transfers, predicts each result transfer and compares them in order.
// Depends on crc8pfr_pkg.

module crc8pfr_checker (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [crc8pfr_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]     s_rx_byte,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]     m_frame_addr,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]     m_frame_type,
    input  logic [crc8pfr_pkg::LEN_W-1:0]      m_frame_len,
    input  logic [crc8pfr_pkg::BYTE_W-1:0]     m_data_byte,
    input  logic [crc8pfr_pkg::IDX_W-1:0]      m_data_index,
    input  logic                               m_last,
    output int                                 mismatches,
    output int                                 pending,
    output int                                 results_seen,
    output int                                 frames_good,
    output int                                 frames_bad_crc,
    output int                                 length_aborts
);
    import crc8pfr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef enum logic [2:0] {
        HUNT,
        TAKE_ADDR,
        TAKE_TYPE,
        TAKE_LEN,
        TAKE_DATA,
        TAKE_CRC
    } rx_phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] addr;
        logic [BYTE_W-1:0] ftype;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  index;
        logic              last;
    } payload_beat_t;

    payload_beat_t     expected_beats[$];
    rx_phase_t         phase;
    logic [BYTE_W-1:0] sync_value;
    logic [LEN_W-1:0]  max_len;
    logic [BYTE_W-1:0] held_addr;
    logic [BYTE_W-1:0] held_type;
    logic [LEN_W-1:0]  held_len;
    logic [LEN_W-1:0]  byte_count;
    logic [BYTE_W-1:0] running_crc;
    logic [BYTE_W-1:0] payload_mem [PAYLOAD_DEPTH];

    // CRC-8, poly 0x07, MSB first
    function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] crc,
                                                    input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] c;
        int k;
        c = crc ^ b;
        for (k = 0; k < 8; k++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic note_mismatch(input string what, input payload_beat_t exp,
                                 input payload_beat_t act);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display({"%0t %s: expected addr=%h type=%h len=%0d data=%h idx=%0d last=%b,",
                      " got addr=%h type=%h len=%0d data=%h idx=%0d last=%b"},
                     $time, what, exp.addr, exp.ftype, exp.len, exp.data, exp.index, exp.last,
                     act.addr, act.ftype, act.len, act.data, act.index, act.last);
    endtask

    // One link byte through the frame state machine.
    task automatic take_link_byte(input logic [BYTE_W-1:0] b);
        payload_beat_t beat;
        int lim;
        int cnt;
        int k;
        case (phase)
            TAKE_ADDR: begin
                held_addr   = b;
                running_crc = crc8_next(running_crc, b);
                phase       = TAKE_TYPE;
            end
            TAKE_TYPE: begin
                held_type   = b;
                running_crc = crc8_next(running_crc, b);
                phase       = TAKE_LEN;
            end
            TAKE_LEN: begin
                // effective maximum is the smallest of register, store depth, result cap
                lim = max_len;
                if (lim > PAYLOAD_DEPTH) lim = PAYLOAD_DEPTH;
                if (lim > RESULT_LIMIT) lim = RESULT_LIMIT;
                if (b > lim) begin
                    phase = HUNT;
                    length_aborts++;
                end else begin
                    held_len    = b[LEN_W-1:0];
                    byte_count  = '0;
                    running_crc = crc8_next(running_crc, b);
                    phase       = (b == 0) ? TAKE_CRC : TAKE_DATA;
                end
            end
            TAKE_DATA: begin
                if (byte_count < PAYLOAD_DEPTH)
                    payload_mem[byte_count] = b;
                byte_count  = byte_count + 1'b1;
                running_crc = crc8_next(running_crc, b);
                if (byte_count >= held_len)
                    phase = TAKE_CRC;
            end
            TAKE_CRC: begin
                phase = HUNT;
                if (running_crc == b) begin
                    cnt = (held_len == 0) ? 1 : held_len;
                    if (cnt > RESULT_LIMIT) cnt = RESULT_LIMIT;
                    for (k = 0; k < cnt; k++) begin
                        beat.addr  = held_addr;
                        beat.ftype = held_type;
                        beat.len   = held_len;
                        beat.data  = (held_len != 0 && k < PAYLOAD_DEPTH) ? payload_mem[k] : '0;
                        beat.index = (held_len != 0) ? k[IDX_W-1:0] : '0;
                        beat.last  = (k == cnt - 1);
                        expected_beats.push_back(beat);
                    end
                    frames_good++;
                end else begin
                    frames_bad_crc++;
                end
            end
            default: begin
                phase = HUNT;
                if (b == sync_value) begin
                    running_crc = '0;
                    phase       = TAKE_ADDR;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin : watch
        payload_beat_t got;
        payload_beat_t exp;
        if (!aresetn) begin
            expected_beats.delete();
            phase          = HUNT;
            sync_value     = SYNC_RESET;
            max_len        = MAX_LEN_RESET;
            held_addr      = '0;
            held_type      = '0;
            held_len       = '0;
            byte_count     = '0;
            running_crc    = '0;
            mismatches     = 0;
            results_seen   = 0;
            frames_good    = 0;
            frames_bad_crc = 0;
            length_aborts  = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.addr  = m_frame_addr;
                got.ftype = m_frame_type;
                got.len   = m_frame_len;
                got.data  = m_data_byte;
                got.index = m_data_index;
                got.last  = m_last;
                results_seen++;
                if (expected_beats.size() == 0) begin
                    note_mismatch("unexpected result", '0, got);
                end else begin
                    exp = expected_beats.pop_front();
                    if (got !== exp)
                        note_mismatch("result mismatch", exp, got);
                end
            end
            // a byte taken on the same edge as a write still sees the old config
            if (s_valid && s_ready)
                take_link_byte(s_rx_byte);
            if (cfg_we) begin
                if (cfg_idx == CFG_SYNC_BYTE)
                    sync_value = cfg_wdata;
                else if (cfg_idx == CFG_MAX_LEN)
                    max_len = cfg_wdata[LEN_W-1:0];
            end
        end
        pending = expected_beats.size();
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Testbench top for crc8_packet_frame_receiver: clock, reset, link byte and
// config stimulus, random backpressure and the verdict.
// Depends on crc8pfr_pkg, the receiver RTL and crc8pfr_checker.

module tb_top;
    import crc8pfr_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 35;
    // a drain needs a payload read and a result load per result, plus margin
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;

    // indexes past the register map; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx   = '0;
    logic [BYTE_W-1:0]    cfg_wdata = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [BYTE_W-1:0]    s_rx_byte = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic [BYTE_W-1:0]    m_frame_addr;
    logic [BYTE_W-1:0]    m_frame_type;
    logic [LEN_W-1:0]     m_frame_len;
    logic [BYTE_W-1:0]    m_data_byte;
    logic [IDX_W-1:0]     m_data_index;
    logic                 m_last;

    // stimulus-side view of the config, used only to shape frames
    logic [BYTE_W-1:0]    sync_value   = SYNC_RESET;
    int                   accept_limit = MAX_LEN_RESET;
    logic [BYTE_W-1:0]    payload_buf [PAYLOAD_DEPTH];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int link_bytes     = 0;
    int frame_items    = 0;
    int cycles         = 0;

    int mismatches;
    int pending;
    int results_seen;
    int frames_good;
    int frames_bad_crc;
    int length_aborts;

    crc8_packet_frame_receiver dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_rx_byte    (s_rx_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_addr (m_frame_addr),
        .m_frame_type (m_frame_type),
        .m_frame_len  (m_frame_len),
        .m_data_byte  (m_data_byte),
        .m_data_index (m_data_index),
        .m_last       (m_last)
    );

    crc8pfr_checker scoreboard (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_idx        (cfg_idx),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_addr   (m_frame_addr),
        .m_frame_type   (m_frame_type),
        .m_frame_len    (m_frame_len),
        .m_data_byte    (m_data_byte),
        .m_data_index   (m_data_index),
        .m_last         (m_last),
        .mismatches     (mismatches),
        .pending        (pending),
        .results_seen   (results_seen),
        .frames_good    (frames_good),
        .frames_bad_crc (frames_bad_crc),
        .length_aborts  (length_aborts)
    );

    always #CLK_HALF aclk = ~aclk;

    // Result side backpressure: a fresh ready decision every cycle, driven on
    // the falling edge so the DUT sees a settled value at the rising edge.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: catches a hung handshake or results that never arrive.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed", cycles, pending);
            $display("crc8_packet_frame_receiver test failed");
            $finish;
        end
    end

    // CRC over the header and payload for building well-formed frames.
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        int k;
        c = crc ^ b;
        for (k = 0; k < 8; k++)
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    // One input transfer. Gaps are drawn per cycle, so with a high idle rate
    // the byte lands on any phase of the receiver's work, drain included.
    // Valid stays high after the transfer until the next call decides.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!(s_valid && s_ready)) @(posedge aclk);
        link_bytes++;
    endtask

    // Sender pause: hold off until every predicted result has been taken, then
    // give the receiver time to finish anything that produces no result.
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Single-cycle register write; only called with s_valid low.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_SYNC_BYTE) begin
            sync_value = value;
        end else if (idx == CFG_MAX_LEN) begin
            accept_limit = value[LEN_W-1:0];
            if (accept_limit > PAYLOAD_DEPTH) accept_limit = PAYLOAD_DEPTH;
        end
    endtask

    // SYNC ADDR TYPE LEN PAYLOAD CRC from payload_buf. An oversize length ends
    // the frame at the length byte; cut truncates it to that many bytes.
    task automatic send_frame(input logic [7:0] addr, input logic [7:0] ftype,
                              input logic [7:0] len, input logic [7:0] crc_flip,
                              input int cut);
        logic [7:0] seq [0:PAYLOAD_DEPTH+4];
        logic [7:0] crc;
        int count;
        int i;
        seq[0] = sync_value;
        seq[1] = addr;
        seq[2] = ftype;
        seq[3] = len;
        count  = 4;
        crc    = crc8_byte(crc8_byte(crc8_byte(8'h00, addr), ftype), len);
        if (len <= accept_limit) begin
            for (i = 0; i < len; i++) begin
                seq[count] = payload_buf[i];
                count++;
                crc = crc8_byte(crc, payload_buf[i]);
            end
            seq[count] = crc ^ crc_flip;
            count++;
        end
        for (i = 0; i < count && i < cut; i++) begin
            send_byte(seq[i]);
            frame_items++;
        end
    endtask

    initial begin
        logic [7:0] crc;
        logic [7:0] sb;
        logic [7:0] ml;
        int p;
        int pick;
        int n;
        int len;

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // ---- directed frames, default config (sync 0xAA, max 16) ----
        // empty payload with extreme header bytes
        send_frame(8'h00, 8'hFF, 8'd0, 8'h00, 99);
        // corrupted CRC: dropped without a result
        send_frame(8'h3C, 8'h11, 8'd0, 8'h01, 99);
        // length one past the maximum: back to hunting at the length byte
        send_frame(8'h12, 8'h34, 8'd17, 8'h00, 99);
        // sync value inside the frame is plain data
        payload_buf[0] = sync_value;
        payload_buf[1] = 8'hFF;
        send_frame(8'hFF, sync_value, 8'd2, 8'h00, 99);

        // max length lowered mid-frame: it governs the length byte yet to come
        send_byte(sync_value);
        send_byte(8'h5A);
        send_byte(8'hC3);
        wait_idle();
        cfg_write(CFG_MAX_LEN, 8'd2);
        send_byte(8'd3);

        // sync changed mid-frame: the frame already started completes
        send_byte(sync_value);
        wait_idle();
        cfg_write(CFG_SYNC_BYTE, 8'h55);
        crc = crc8_byte(crc8_byte(crc8_byte(8'h00, 8'h01), 8'h02), 8'h00);
        send_byte(8'h01);
        send_byte(8'h02);
        send_byte(8'h00);
        send_byte(crc);

        // writes past the register map leave sync 0x55 / max 2 in force
        wait_idle();
        cfg_write(CFG_SPARE_A, 8'h00);
        cfg_write(CFG_SPARE_B, 8'h00);
        payload_buf[0] = 8'h7F;
        send_frame(8'h80, 8'h01, 8'd1, 8'h00, 99);

        // ---- random phases: config and idle pattern change at each pause ----
        for (p = 0; p < PHASE_COUNT; p++) begin
            wait_idle();
            case (p % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 17; recv_stall_pct = 17; end
            endcase
            case (p)
                0:       begin sb = SYNC_RESET; ml = 8'd16; end
                1:       begin sb = 8'h00; ml = 8'd0;  end  // only empty frames pass
                2:       begin sb = 8'hFF; ml = 8'hFF; end  // 31 after masking, capped at 16
                3:       begin sb = 8'h7E; ml = 8'd1;  end
                4:       begin sb = 8'($urandom); ml = 8'h20; end  // masks to zero
                5:       begin sb = 8'($urandom); ml = 8'd16; end
                default: begin sb = 8'($urandom); ml = 8'($urandom_range(16)); end
            endcase
            cfg_write(CFG_SYNC_BYTE, sb);
            cfg_write(CFG_MAX_LEN, ml);

            frame_items = 0;
            while (frame_items < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                len  = ($urandom_range(3) == 0) ? accept_limit : $urandom_range(accept_limit);
                for (n = 0; n < PAYLOAD_DEPTH; n++)
                    payload_buf[n] = ($urandom_range(9) == 0) ? sync_value : 8'($urandom);
                if (pick < 72) begin
                    // well-formed, one in seven with a corrupted CRC
                    send_frame(8'($urandom), 8'($urandom), 8'(len),
                               ($urandom_range(6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                               99);
                end else if (pick < 84) begin
                    // oversize length, often just one past the limit
                    n = ($urandom_range(1) == 0) ? accept_limit + 1
                                                 : $urandom_range(accept_limit + 1, 255);
                    send_frame(8'($urandom), 8'($urandom), 8'(n), 8'h00, 99);
                end else if (pick < 93) begin
                    // truncated frame; what follows gets parsed as its tail
                    send_frame(8'($urandom), 8'($urandom), 8'(len), 8'h00,
                               $urandom_range(1, len + 4));
                end else begin
                    // line noise, not counted toward the phase
                    repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
                end
            end
        end

        wait_idle();

        $display("Drove %0d link bytes: directed frames, then %0d phases of config and idle mixes.",
                 link_bytes, PHASE_COUNT);
        $display("%0d frames delivered as %0d results, %0d bad-CRC drops, %0d length aborts.",
                 frames_good, results_seen, frames_bad_crc, length_aborts);
        if (mismatches == 0 && pending == 0) begin
            $display("crc8_packet_frame_receiver test passed");
        end else begin
            $display("crc8_packet_frame_receiver test failed");
        end
        $finish;
    end

endmodule
